// File: design/dou_pkg.sv
// Shared types, constants and the month-length table for the date offset unit.
// No dependencies; imported by every module of the block.
package dou_pkg;

  localparam int unsigned DAY_W = 5;
  localparam int unsigned MON_W = 4;
  localparam int unsigned YEAR_W = 14;
  localparam int unsigned OFF_W = 16;
  localparam int unsigned ST_W = 2;
  localparam int unsigned T_W = OFF_W + 1;  // running day count, signed
  localparam int unsigned STEP_W = 4;

  localparam logic [OFF_W:0] MAX_OFFSET = 17'sd32767;
  localparam logic [YEAR_W-1:0] YEAR_MAX = 14'd9999;
  localparam logic [MON_W-1:0] MONTHS = 4'd12;

  // y / 100 as (y * 5243) >> 19, exact for every 14-bit y
  localparam int unsigned QUO_W = 8;
  localparam int unsigned REM_W = 7;
  localparam int unsigned DIV100_MUL = 5243;
  localparam int unsigned DIV100_SH = 19;
  localparam int unsigned PROD_W = 27;
  localparam logic [REM_W-1:0] REM_LAST = 7'd99;

  localparam logic [ST_W-1:0] ST_OK = 2'd0;
  localparam logic [ST_W-1:0] ST_BAD_DATE = 2'd1;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd2;

  typedef logic [STEP_W-1:0] step_t;

  typedef enum logic [2:0] {
    OP_NOP   = 3'd0,
    OP_DIV1  = 3'd1,
    OP_DIV2  = 3'd2,
    OP_FWD   = 3'd3,
    OP_BWD   = 3'd4,
    OP_OK    = 3'd5,
    OP_RANGE = 3'd6,
    OP_BAD   = 3'd7
  } op_t;

  typedef enum logic [2:0] {
    C_NEVER    = 3'd0,
    C_NO_INPUT = 3'd1,
    C_INVALID  = 3'd2,
    C_FWD_DONE = 3'd3,
    C_BWD_DONE = 3'd4,
    C_OVF      = 3'd5,
    C_OUT_BUSY = 3'd6
  } cond_t;

  // one microcode word: op runs only when cond is false
  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t tgt;
    logic  hold;  // stay on this step while cond is false
    logic  fin;   // return to the first step after this one
  } ctrl_t;

  typedef struct packed {
    logic invalid;
    logic fwd_done;
    logic bwd_done;
    logic ovf;
  } dp_flags_t;

  typedef struct packed {
    logic [DAY_W-1:0]  day;
    logic [MON_W-1:0]  month;
    logic [YEAR_W-1:0] year;
    logic [ST_W-1:0]   status;
  } result_t;

  function automatic logic [DAY_W-1:0] month_len(input logic [MON_W-1:0] m, input logic leap);
    logic [DAY_W-1:0] len;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:                                       len = leap ? 5'd29 : 5'd28;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

endpackage

// File: design/dou_seq.sv
// Microcode sequencer: program ROM, step counter and conditional jumps.
// Depends on dou_pkg; drives dou_dp through the op code.
module dou_seq (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               out_busy,
  input  dou_pkg::dp_flags_t flags,
  output dou_pkg::op_t       op,
  output logic               idle
);
  import dou_pkg::*;

  localparam step_t S_WAIT = 4'd0;
  localparam step_t S_DIV1 = 4'd1;
  localparam step_t S_DIV2 = 4'd2;
  localparam step_t S_CHK = 4'd3;
  localparam step_t S_FWD = 4'd4;
  localparam step_t S_FCHK = 4'd5;
  localparam step_t S_BWD = 4'd6;
  localparam step_t S_BCHK = 4'd7;
  localparam step_t S_OK = 4'd8;
  localparam step_t S_RANGE = 4'd9;
  localparam step_t S_BAD = 4'd10;

  function automatic ctrl_t rom(input step_t s);
    ctrl_t w;
    case (s)
      S_WAIT:  w = '{OP_NOP,   C_NO_INPUT, S_WAIT,  1'b0, 1'b0};
      S_DIV1:  w = '{OP_DIV1,  C_NEVER,    S_WAIT,  1'b0, 1'b0};
      S_DIV2:  w = '{OP_DIV2,  C_NEVER,    S_WAIT,  1'b0, 1'b0};
      S_CHK:   w = '{OP_NOP,   C_INVALID,  S_BAD,   1'b0, 1'b0};
      S_FWD:   w = '{OP_FWD,   C_FWD_DONE, S_FCHK,  1'b1, 1'b0};
      S_FCHK:  w = '{OP_NOP,   C_OVF,      S_RANGE, 1'b0, 1'b0};
      S_BWD:   w = '{OP_BWD,   C_BWD_DONE, S_BCHK,  1'b1, 1'b0};
      S_BCHK:  w = '{OP_NOP,   C_OVF,      S_RANGE, 1'b0, 1'b0};
      S_OK:    w = '{OP_OK,    C_OUT_BUSY, S_OK,    1'b0, 1'b1};
      S_RANGE: w = '{OP_RANGE, C_OUT_BUSY, S_RANGE, 1'b0, 1'b1};
      S_BAD:   w = '{OP_BAD,   C_OUT_BUSY, S_BAD,   1'b0, 1'b1};
      default: w = '{OP_NOP,   C_NEVER,    S_WAIT,  1'b0, 1'b1};
    endcase
    return w;
  endfunction

  step_t step_r, step_nxt;
  ctrl_t cw;
  logic  hit;

  assign cw = rom(step_r);

  always_comb begin
    case (cw.cond)
      C_NEVER:    hit = 1'b0;
      C_NO_INPUT: hit = !in_valid;
      C_INVALID:  hit = flags.invalid;
      C_FWD_DONE: hit = flags.fwd_done;
      C_BWD_DONE: hit = flags.bwd_done;
      C_OVF:      hit = flags.ovf;
      C_OUT_BUSY: hit = out_busy;
      default:    hit = 1'b0;
    endcase
  end

  always_comb begin
    if (hit) begin
      step_nxt = cw.tgt;
    end else if (cw.hold) begin
      step_nxt = step_r;
    end else if (cw.fin) begin
      step_nxt = S_WAIT;
    end else begin
      step_nxt = step_r + 1'b1;
    end
  end

  assign op = hit ? OP_NOP : cw.op;
  assign idle = (step_r == S_WAIT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= S_WAIT;
    end else begin
      step_r <= step_nxt;
    end
  end

endmodule

// File: design/dou_dp.sv
// Datapath of the date offset unit: date registers, leap tracking, month walk.
// Depends on dou_pkg; driven by the op code from dou_seq.
module dou_dp (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         load,
  input  logic [dou_pkg::DAY_W-1:0]    day_in,
  input  logic [dou_pkg::MON_W-1:0]    month_in,
  input  logic [dou_pkg::YEAR_W-1:0]   year_in,
  input  logic signed [dou_pkg::OFF_W-1:0] day_offset,
  input  dou_pkg::op_t                 op,
  output dou_pkg::dp_flags_t           flags,
  output logic                         res_wr,
  output dou_pkg::result_t             res
);
  import dou_pkg::*;

  logic [DAY_W-1:0]         d_r;
  logic [MON_W-1:0]         m_r, m_nxt;
  logic [YEAR_W-1:0]        y_r, y_nxt;
  logic signed [T_W-1:0]    t_r, t_nxt;
  logic [QUO_W-1:0]         q_r, q_nxt;
  logic [REM_W-1:0]         rem_r, rem_nxt;   // year mod 100
  logic [1:0]               q2_r, q2_nxt;     // (year / 100) mod 4
  logic                     ovf_r, ovf_nxt;

  logic signed [T_W-1:0]    off_sat;
  logic [PROD_W-1:0]        prod;
  logic [YEAR_W-1:0]        hund;
  logic                     leap;
  logic [MON_W-1:0]         m_prev;
  logic [DAY_W-1:0]         len_cur, len_prev;

  // magnitude clamps at MAX_OFFSET
  always_comb begin
    off_sat = T_W'(day_offset);
    if (off_sat > $signed(MAX_OFFSET)) begin
      off_sat = $signed(MAX_OFFSET);
    end else if (off_sat < -$signed(MAX_OFFSET)) begin
      off_sat = -$signed(MAX_OFFSET);
    end
  end

  assign prod = PROD_W'(y_r) * PROD_W'(DIV100_MUL);
  assign hund = YEAR_W'(q_r) * YEAR_W'(100);

  assign leap = (y_r[1:0] == 2'b00) && ((rem_r != '0) || (q2_r == 2'b00));
  assign m_prev = (m_r == 4'd1) ? MONTHS : m_r - 1'b1;
  // going back across a year boundary lands in December, whose length ignores leap
  assign len_cur = month_len(m_r, leap);
  assign len_prev = month_len(m_prev, leap);

  assign flags.invalid = (m_r == '0) || (m_r > MONTHS) || (y_r == '0) || (y_r > YEAR_MAX)
                       || (d_r == '0) || (d_r > len_cur);
  assign flags.fwd_done = (t_r <= $signed(T_W'(len_cur)));
  assign flags.bwd_done = (t_r >= $signed(T_W'(1)));
  assign flags.ovf = ovf_r;

  always_comb begin
    m_nxt = m_r;
    y_nxt = y_r;
    t_nxt = t_r;
    q_nxt = q_r;
    rem_nxt = rem_r;
    q2_nxt = q2_r;
    ovf_nxt = ovf_r;
    if (load) begin
      m_nxt = month_in;
      y_nxt = year_in;
      t_nxt = T_W'(day_in) + off_sat;
      ovf_nxt = 1'b0;
    end else begin
      case (op)
        OP_DIV1: q_nxt = prod[DIV100_SH +: QUO_W];
        OP_DIV2: begin
          rem_nxt = REM_W'(y_r - hund);
          q2_nxt = q_r[1:0];
        end
        OP_FWD: begin
          t_nxt = t_r - $signed(T_W'(len_cur));
          if (m_r == MONTHS) begin
            m_nxt = 4'd1;
            y_nxt = y_r + 1'b1;
            if (y_r == YEAR_MAX) begin
              ovf_nxt = 1'b1;
            end
            if (rem_r == REM_LAST) begin
              rem_nxt = '0;
              q2_nxt = q2_r + 1'b1;
            end else begin
              rem_nxt = rem_r + 1'b1;
            end
          end else begin
            m_nxt = m_r + 1'b1;
          end
        end
        OP_BWD: begin
          t_nxt = t_r + $signed(T_W'(len_prev));
          m_nxt = m_prev;
          if (m_r == 4'd1) begin
            y_nxt = y_r - 1'b1;
            if (y_r == YEAR_W'(1)) begin
              ovf_nxt = 1'b1;
            end
            if (rem_r == '0) begin
              rem_nxt = REM_LAST;
              q2_nxt = q2_r - 1'b1;
            end else begin
              rem_nxt = rem_r - 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    res_wr = 1'b0;
    res = '0;
    case (op)
      OP_OK: begin
        res_wr = 1'b1;
        res.day = t_r[DAY_W-1:0];
        res.month = m_r;
        res.year = y_r;
        res.status = ST_OK;
      end
      OP_RANGE: begin
        res_wr = 1'b1;
        res.status = ST_RANGE;
      end
      OP_BAD: begin
        res_wr = 1'b1;
        res.status = ST_BAD_DATE;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (load) begin
      d_r <= day_in;
    end
    m_r <= m_nxt;
    y_r <= y_nxt;
    t_r <= t_nxt;
    q_r <= q_nxt;
    rem_r <= rem_nxt;
    q2_r <= q2_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovf_r <= 1'b0;
    end else begin
      ovf_r <= ovf_nxt;
    end
  end

endmodule

// File: design/date_offset_unit.sv
// Date offset unit: Gregorian date plus a signed day count; top level and output register.
// Depends on dou_pkg, dou_seq and dou_dp.
//
// One item at a time. After an item is taken, the DIV1 and DIV2 steps divide the year by 100
// for the leap rule and the CHK step checks the date; an invalid date goes on to the BAD
// output step. A valid date is then walked month by month, forward or backward, by the
// shared month-step datapath, with a done test and a year-range check step per direction,
// and then an output step writes the result. The next item is taken once the sequencer is
// back in its wait step; a result waiting in the output register does not hold up the
// walk, only the final write.
module date_offset_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // day_in[4:0], month_in[8:5], year_in[22:9], day_offset[38:23]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata   // day_out[4:0], month_out[8:5], year_out[22:9], status[24:23]
);
  import dou_pkg::*;

  dp_flags_t flags;
  op_t       op;
  logic      idle;
  logic      in_fire;
  logic      out_busy;
  logic      res_wr;
  result_t   res;
  logic      out_tvalid_r, out_tvalid_nxt;
  result_t   out_res_r;

  assign in_tready = idle;
  assign in_fire = in_tvalid && in_tready;
  assign out_busy = out_tvalid_r && !out_tready;

  dou_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .out_busy (out_busy),
    .flags    (flags),
    .op       (op),
    .idle     (idle)
  );

  dou_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (in_fire),
    .day_in     (in_tdata[4:0]),
    .month_in   (in_tdata[8:5]),
    .year_in    (in_tdata[22:9]),
    .day_offset ($signed(in_tdata[38:23])),
    .op         (op),
    .flags      (flags),
    .res_wr     (res_wr),
    .res        (res)
  );

  always_comb begin
    out_tvalid_nxt = out_tvalid_r;
    if (res_wr) begin
      out_tvalid_nxt = 1'b1;
    end else if (out_tready) begin
      out_tvalid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else begin
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_wr) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata = {7'b0, out_res_r.status, out_res_r.year, out_res_r.month, out_res_r.day};

  // a result never overwrites one that is still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    res_wr |-> !out_busy)
    else $error("result written while output register is stalled");

  // an accept takes the sequencer off its wait step, so in_tready drops right after it
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_tready)
    else $error("input taken again right after an accept");

  // a good result always carries a month from 1 to 12 and a nonzero day
  a_ok_date: assert property (@(posedge clk) disable iff (!rst_n)
    (res_wr && res.status == ST_OK) |->
      (res.month >= 4'd1 && res.month <= MONTHS && res.day != '0))
    else $error("ok result with an impossible date");

  // results only come while the sequencer is off its wait step
  a_wr_not_idle: assert property (@(posedge clk) disable iff (!rst_n)
    res_wr |-> !idle)
    else $error("result written from the wait step");

endmodule
